[hw/rtl/buddy_block_allocator_assert.svh]
// ----------------------------------------------------------------------------
// buddy_block_allocator_assert.svh
// assertion macros for the buddy block allocator
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define BBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bba assertion failed");
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bba assertion failed");
`else
`define BBA_ASSERT_IMPL(lbl, ante, cons)
`define BBA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and codes of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int DEF_TOTAL_UNITS = 1024;

  localparam int OPCODE_W = 1;
  localparam int SIZE_W   = 11;
  localparam int OFFSET_W = 10;
  localparam int STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_GRANTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FREED   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd3;

  typedef enum logic [1:0] {
    KIND_ABSENT = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_ALLOC  = 2'd2,
    KIND_SPLIT  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DESC = 3'b010,
    S_ASC  = 3'b100
  } state_t;

endpackage

[hw/rtl/bba_node_ram.sv]
// ----------------------------------------------------------------------------
// bba_node_ram
// child pair memory, one entry per inner node, registered read
// ----------------------------------------------------------------------------
module bba_node_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/buddy_block_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator
// buddy allocator over a heap of TOTAL_UNITS units kept as a binary node tree
// ----------------------------------------------------------------------------
// One request at a time. A rejected request (bad size, no room, offset out of
// range) answers in the cycle after it is taken. Any other request walks
// the tree down one level per cycle, one child-pair memory read per level,
// then back up one level per cycle, one pair write per level to refresh the
// largest-free summaries and merge buddies. An ignored free answers after
// the way down. No clearing pass is needed after reset: the root lives in
// flip-flops and a pair entry is always written before it is read.
// ----------------------------------------------------------------------------
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int TOTAL_UNITS = DEF_TOTAL_UNITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [SIZE_W-1:0]   request_size,
  input  logic [OFFSET_W-1:0] free_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [OFFSET_W-1:0] block_offset
);

  `include "buddy_block_allocator_assert.svh"

  localparam int LG   = $clog2(TOTAL_UNITS);
  localparam int DW   = $clog2(LG + 1);
  localparam int MFW  = $clog2(LG + 2);
  localparam int IDXW = LG + 1;
  localparam int SW   = (LG > 1) ? $clog2(LG) : 1;

  typedef struct packed {
    kind_t          kind;
    logic [MFW-1:0] mf;
  } info_t;

  typedef struct packed {
    info_t l;
    info_t r;
  } pair_t;

  localparam int PW = $bits(pair_t);

  state_t              state;
  logic [OPCODE_W-1:0] op;
  logic [DW-1:0]       wlg;
  logic [LG-1:0]       off;
  logic [DW-1:0]       depth;
  logic [IDXW-1:0]     idx;
  logic [LG-1:0]       base;
  info_t               cur;
  info_t               root;
  logic                merging;
  pair_t               stack [LG];

  logic          ram_we;
  logic [LG-1:0] ram_waddr;
  logic [LG-1:0] ram_raddr;
  logic [PW-1:0] ram_rdata;
  pair_t         rd;
  pair_t         up;

  logic [DW-1:0]   lg_calc;
  logic            pow2;
  logic            size_ok;
  logic            room_ok;
  logic            off_ok;
  logic [31:0]     off_ext;
  logic [31:0]     base_ext;
  logic [DW-1:0]   cur_lg;
  logic [DW-1:0]   sh;
  logic            pick;
  logic [IDXW-1:0] child_idx;
  info_t           child;
  pair_t           push;
  logic [LG-1:0]   half;
  logic [DW-1:0]   depth_m1;
  logic            merge_up;
  logic [MFW-1:0]  max_mf;
  logic            accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign off_ext  = 32'(free_offset);
  assign base_ext = 32'(base);
  assign rd       = ram_rdata;

  // request decode
  always_comb begin
    lg_calc = '0;
    pow2    = 1'b0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (request_size == SIZE_W'(1 << i)) begin
        pow2    = 1'b1;
        lg_calc = DW'(i);
      end
    end
    size_ok = pow2 && (32'(request_size) <= 32'(TOTAL_UNITS));
    room_ok = 32'(root.mf) >= (32'(lg_calc) + 32'd1);
    off_ok  = off_ext < 32'(TOTAL_UNITS);
  end

  // descent step
  always_comb begin
    cur_lg = DW'(LG) - depth;
    sh     = cur_lg - DW'(1);
    half   = LG'(1) << sh;
    if (cur.kind != KIND_SPLIT) begin
      pick = 1'b0;
    end else if (op == OP_ALLOC) begin
      pick = !(rd.l.mf >= (MFW'(wlg) + MFW'(1)));
    end else begin
      pick = off[sh];
    end
    child_idx = {idx[IDXW-2:0], pick};
    if (cur.kind == KIND_SPLIT) begin
      child = pick ? rd.r : rd.l;
      push  = rd;
    end else begin
      child  = '{kind: KIND_FREE, mf: MFW'(cur_lg)};
      push.l = '{kind: KIND_ABSENT, mf: '0};
      push.r = '{kind: KIND_FREE, mf: MFW'(cur_lg)};
    end
  end

  // ascent step
  always_comb begin
    depth_m1 = depth - DW'(1);
    up       = stack[depth_m1[SW-1:0]];
    if (idx[0]) begin
      up.r = cur;
    end else begin
      up.l = cur;
    end
    merge_up = merging && (up.l.kind == KIND_FREE) && (up.r.kind == KIND_FREE);
    max_mf   = (up.l.mf > up.r.mf) ? up.l.mf : up.r.mf;
  end

  assign ram_we    = (state == S_ASC) && (depth != '0);
  assign ram_waddr = idx[LG:1];
  assign ram_raddr = (state == S_DESC) ? child_idx[LG-1:0] : LG'(1);

  bba_node_ram #(
    .ADDR_W (LG),
    .DATA_W (PW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (up),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      root      <= '{kind: KIND_FREE, mf: MFW'(LG) + MFW'(1)};
      merging   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= opcode;
            wlg   <= lg_calc;
            off   <= off_ext[LG-1:0];
            depth <= '0;
            idx   <= IDXW'(1);
            base  <= '0;
            cur   <= root;
            if (opcode == OP_ALLOC && !(size_ok && room_ok)) begin
              out_valid    <= 1'b1;
              status       <= STAT_NOSPACE;
              block_offset <= '0;
            end else if (opcode == OP_FREE && !off_ok) begin
              out_valid    <= 1'b1;
              status       <= STAT_IGNORED;
              block_offset <= '0;
            end else begin
              state <= S_DESC;
            end
          end
        end
        S_DESC: begin
          if (op == OP_ALLOC && cur_lg == wlg) begin
            cur     <= '{kind: KIND_ALLOC, mf: '0};
            merging <= 1'b0;
            state   <= S_ASC;
          end else if (op == OP_ALLOC || cur.kind == KIND_SPLIT) begin
            stack[depth[SW-1:0]] <= push;
            cur   <= child;
            idx   <= child_idx;
            base  <= pick ? (base | half) : base;
            depth <= depth + DW'(1);
          end else if (cur.kind == KIND_ALLOC && base == off) begin
            cur     <= '{kind: KIND_FREE, mf: MFW'(cur_lg) + MFW'(1)};
            merging <= 1'b1;
            state   <= S_ASC;
          end else begin
            out_valid    <= 1'b1;
            status       <= STAT_IGNORED;
            block_offset <= '0;
            state        <= S_IDLE;
          end
        end
        S_ASC: begin
          if (depth == '0) begin
            root         <= cur;
            out_valid    <= 1'b1;
            status       <= (op == OP_ALLOC) ? STAT_GRANTED : STAT_FREED;
            block_offset <= base_ext[OFFSET_W-1:0];
            state        <= S_IDLE;
          end else begin
            if (merge_up) begin
              cur <= '{kind: KIND_FREE, mf: MFW'(cur_lg) + MFW'(2)};
            end else begin
              cur     <= '{kind: KIND_SPLIT, mf: max_mf};
              merging <= 1'b0;
            end
            idx   <= idx >> 1;
            depth <= depth_m1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BBA_ASSERT_NEXT(a_accept_starts, accept, out_valid || state != S_IDLE)
  `BBA_ASSERT_IMPL(a_busy_not_ready, state != S_IDLE, !in_ready)
  `BBA_ASSERT_NEXT(a_root_done, state == S_ASC && depth == '0, out_valid && state == S_IDLE)
  `BBA_ASSERT_IMPL(a_desc_depth, state == S_DESC, depth <= DW'(LG))

endmodule

[sim/buddy_block_allocator_tb.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_tb
// random and directed allocate/free traffic checked against a tree model
// ----------------------------------------------------------------------------
// A table of directed requests opens the run. Random alloc/free traffic
// follows, with random gaps on both sides, a long hold on the result side
// and a pause until the block drains. Every result beat is compared with
// the oldest prediction from a behavioral copy of the node tree.
// ----------------------------------------------------------------------------
module buddy_block_allocator_tb;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNITS = DEF_TOTAL_UNITS;
  localparam int SLOTS = 2 * UNITS;

  typedef struct packed {
    logic [STATUS_W-1:0] stat;
    logic [OFFSET_W-1:0] offs;
  } answer_t;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [SIZE_W-1:0]   size;
    logic [OFFSET_W-1:0] offs;
    bit                  known;
    answer_t             ans;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OPCODE_W-1:0] opcode = OP_ALLOC;
  logic [SIZE_W-1:0]   request_size = '0;
  logic [OFFSET_W-1:0] free_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] block_offset;

  kind_t   tree[SLOTS];
  answer_t pending[$];
  int      live[$];
  bit      failed = 1'b0;
  bit      hold_out = 1'b0;
  bit      sending = 1'b1;
  row_t    rows[$];

  buddy_block_allocator i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit carve(int idx, int nsize, int want, int base, output int got);
    if (idx >= SLOTS || nsize < want) return 0;
    if (nsize == want) begin
      if (tree[idx] != KIND_FREE) return 0;
      tree[idx] = KIND_ALLOC;
      got = base;
      return 1;
    end
    if (nsize < 2 || 2 * idx + 1 >= SLOTS) return 0;
    if (tree[idx] == KIND_FREE) begin
      tree[idx] = KIND_SPLIT;
      tree[2 * idx] = KIND_FREE;
      tree[2 * idx + 1] = KIND_FREE;
      return carve(2 * idx, nsize / 2, want, base, got);
    end
    if (tree[idx] == KIND_SPLIT) begin
      if (carve(2 * idx, nsize / 2, want, base, got)) return 1;
      return carve(2 * idx + 1, nsize / 2, want, base + nsize / 2, got);
    end
    return 0;
  endfunction

  function automatic bit reclaim(int off);
    int idx, nsize, base;
    idx = 1;
    nsize = UNITS;
    base = 0;
    if (off >= UNITS) return 0;
    while (tree[idx] == KIND_SPLIT && nsize > 1 && 2 * idx + 1 < SLOTS) begin
      nsize = nsize / 2;
      if (off >= base + nsize) begin
        idx = 2 * idx + 1;
        base += nsize;
      end else begin
        idx = 2 * idx;
      end
    end
    if (tree[idx] != KIND_ALLOC || base != off) return 0;
    tree[idx] = KIND_FREE;
    while (idx > 1 && tree[idx] == KIND_FREE && tree[idx ^ 1] == KIND_FREE) begin
      tree[idx] = KIND_ABSENT;
      tree[idx ^ 1] = KIND_ABSENT;
      idx = idx / 2;
      tree[idx] = KIND_FREE;
    end
    return 1;
  endfunction

  function automatic answer_t predict_block(logic [OPCODE_W-1:0] op,
                                            logic [SIZE_W-1:0] size,
                                            logic [OFFSET_W-1:0] off);
    answer_t a;
    int got;
    got = 0;
    if (op == OP_ALLOC) begin
      if (size != 0 && (size & (size - 1)) == 0 && size <= UNITS
          && carve(1, UNITS, size, 0, got)) begin
        a.stat = STAT_GRANTED;
        a.offs = OFFSET_W'(got);
        live.push_back(got);
      end else begin
        a.stat = STAT_NOSPACE;
        a.offs = '0;
      end
    end else if (reclaim(off)) begin
      a.stat = STAT_FREED;
      a.offs = off;
      foreach (live[i]) if (live[i] == off) begin
        live.delete(i);
        break;
      end
    end else begin
      a.stat = STAT_IGNORED;
      a.offs = '0;
    end
    return a;
  endfunction

  task automatic send_beat(logic [OPCODE_W-1:0] op, logic [SIZE_W-1:0] size,
                           logic [OFFSET_W-1:0] off, bit known, answer_t ans);
    answer_t p;
    int gap;
    gap = $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    request_size <= size;
    free_offset <= off;
    do @(posedge clk); while (!in_ready);
    p = predict_block(op, size, off);
    if (known && p.stat != ans.stat) begin
      $error("status expected %0d actual %0d", ans.stat, p.stat);
      failed = 1'b1;
    end
    if (known && p.offs != ans.offs) begin
      $error("block_offset expected %0d actual %0d", ans.offs, p.offs);
      failed = 1'b1;
    end
    pending.push_back(p);
    @(negedge clk);
  endtask

  function automatic row_t mk(logic [OPCODE_W-1:0] op, int size, int off,
                              bit known = 0, logic [STATUS_W-1:0] st = '0,
                              int ro = 0);
    row_t r;
    r.op = op;
    r.size = SIZE_W'(size);
    r.offs = OFFSET_W'(off);
    r.known = known;
    r.ans.stat = st;
    r.ans.offs = OFFSET_W'(ro);
    return r;
  endfunction

  task automatic random_beat();
    int pick, sz;
    pick = $urandom_range(0, 99);
    sz = 1 << $urandom_range(0, 5);
    if ($urandom_range(0, 19) == 0) sz = 1 << $urandom_range(0, 10);
    if (pick < 50) begin
      send_beat(OP_ALLOC, SIZE_W'(sz), OFFSET_W'($urandom), 0, '0);
    end else if (pick < 85 && live.size() > 0) begin
      send_beat(OP_FREE, SIZE_W'($urandom),
                OFFSET_W'(live[$urandom_range(0, live.size() - 1)]), 0, '0);
    end else if (pick < 92) begin
      send_beat(OP_ALLOC, SIZE_W'($urandom), OFFSET_W'($urandom), 0, '0);
    end else begin
      send_beat(OP_FREE, SIZE_W'($urandom), OFFSET_W'($urandom), 0, '0);
    end
  endtask

  initial begin
    foreach (tree[i]) tree[i] = KIND_ABSENT;
    tree[1] = KIND_FREE;
    rows = '{
      mk(OP_ALLOC, 0, 0, 1, STAT_NOSPACE, 0),
      mk(OP_ALLOC, 3, 0, 1, STAT_NOSPACE, 0),
      mk(OP_ALLOC, 2047, 1023, 1, STAT_NOSPACE, 0),
      mk(OP_ALLOC, 1025, 0, 1, STAT_NOSPACE, 0),
      mk(OP_FREE, 0, 0, 1, STAT_IGNORED, 0),
      mk(OP_ALLOC, 1024, 0, 1, STAT_GRANTED, 0),
      mk(OP_ALLOC, 1, 0, 1, STAT_NOSPACE, 0),
      mk(OP_FREE, 2047, 1023, 1, STAT_IGNORED, 0),
      mk(OP_FREE, 0, 0, 1, STAT_FREED, 0),
      mk(OP_ALLOC, 1, 0, 1, STAT_GRANTED, 0),
      mk(OP_ALLOC, 1, 0, 1, STAT_GRANTED, 1),
      mk(OP_ALLOC, 2, 0),
      mk(OP_ALLOC, 512, 0),
      mk(OP_ALLOC, 512, 0),
      mk(OP_FREE, 0, 1),
      mk(OP_FREE, 0, 1),
      mk(OP_FREE, 0, 3),
      mk(OP_FREE, 0, 512),
      mk(OP_ALLOC, 256, 0),
      mk(OP_FREE, 0, 0),
      mk(OP_FREE, 0, 2),
      mk(OP_FREE, 0, 512)
    };
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_beat(rows[i].op, rows[i].size, rows[i].offs,
                                rows[i].known, rows[i].ans);
    for (int n = 0; n < 700; n++) begin
      if (n == 200) hold_out = 1'b1;
      if (n == 400) begin
        in_valid <= 1'b0;
        while (pending.size() > 0) @(negedge clk);
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end
      if (n > 450 && n < 520 && live.size() > 0)
        send_beat(OP_FREE, SIZE_W'($urandom), OFFSET_W'(live[0]), 0, '0);
      else
        random_beat();
    end
    in_valid <= 1'b0;
    sending = 1'b0;
  end

  initial begin
    int waits;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_out = 1'b0;
      end
      waits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (waits == 0) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (waits) @(negedge clk);
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: status %0d offset %0d",
               status, block_offset);
        failed = 1'b1;
      end else begin
        e = pending.pop_front();
        if (status !== e.stat) begin
          $error("status expected %0d actual %0d", e.stat, status);
          failed = 1'b1;
        end
        if (block_offset !== e.offs) begin
          $error("block_offset expected %0d actual %0d", e.offs, block_offset);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    wait (!rst);
    wait (!sending);
    while (pending.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
